[src/snh_pkg.sv]
// Shared types and constants for the Sobel height-map normal generator.
// No dependencies; every module in src imports this package.
package snh_pkg;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int DISP_W      = 16;
	localparam int POS_W       = 10;
	localparam int OUT_W       = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int NORM_W      = 31;
	localparam int SQ_W        = 64;
	localparam int ROOT_W      = 32;
	localparam int QUOT_W      = 17;
	localparam int DIV_W       = 50;
	localparam int STEP_W      = 6;
	localparam int ROOT_STEPS  = 32;
	localparam int DIV_STEPS   = 17;
	localparam logic [QUOT_W-1:0] Q15_MAX = QUOT_W'(32767);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH    = 2'd0,
		REG_MAP_HEIGHT   = 2'd1,
		REG_DISPLACEMENT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last;
	} pos_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_NORM,
		B_SQ,
		B_SQRT,
		B_PREP,
		B_DIV,
		B_DONE
	} back_state_t;

	function automatic logic [OUT_W-1:0] to_q15(input logic neg, input logic [QUOT_W-1:0] quo);
		logic [OUT_W-1:0] mag;
		mag = (quo > Q15_MAX) ? OUT_W'(Q15_MAX) : OUT_W'(quo);
		return neg ? (OUT_W'(0) - mag) : mag;
	endfunction

endpackage

[src/snh_front.sv]
// Front end: takes height words, keeps the two-row line store and the 3x3 window,
// and produces the Sobel differences of each emitted position. Uses snh_pkg.
module snh_front
	import snh_pkg::*;
#(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 1024,
	parameter int HEIGHT_BITS = 16,
	localparam int WEW = $clog2(MAX_WIDTH + 1),
	localparam int HEW = $clog2(MAX_HEIGHT + 1),
	localparam int DW  = HEIGHT_BITS + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic signed [HEIGHT_BITS-1:0] height_sample,
	input  logic [WEW-1:0]                width_eff,
	input  logic [HEW-1:0]                height_eff,
	input  logic                          frame_clear,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
	output logic                          push,
	output logic signed [DW-1:0]          push_dx,
	output logic signed [DW-1:0]          push_dz,
	output pos_t                          push_pos
);

	localparam int HB  = HEIGHT_BITS;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT + 2);
	localparam int ORW = $clog2(MAX_HEIGHT);
	localparam int WX  = WEW + 1;
	localparam int HX  = RW + 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic emit;
		logic pre;
		logic left_edge;
		logic top_first;
		logic bot_last;
		logic last;
		logic parity;
		pos_t pos;
	} front_ctl_t;

	logic [CW-1:0]  in_col_q;
	logic [RW-1:0]  in_row_q;
	logic [CW-1:0]  out_col_q;
	logic [ORW-1:0] out_row_q;
	logic           loaded_q;

	logic [HB-1:0] bank0_q [MAX_WIDTH];
	logic [HB-1:0] bank1_q [MAX_WIDTH];
	logic [HB-1:0] rd0_s1, rd1_s1;
	logic signed [HB-1:0] sample_s1;
	logic          valid_s1;
	front_ctl_t    ctl_s1;

	logic signed [HB-1:0] win_q [3][3];

	logic          accept, drop, take;
	logic [CW-1:0] ic;
	logic          emit, pre, last, col_end, in_last_row;
	front_ctl_t    ctl;

	assign in_stall = (QCW'(valid_s1) + q_count) >= QCW'(QUEUE_DEPTH);
	assign accept   = in_valid && !in_stall;
	assign drop     = mode ? !loaded_q : loaded_q;
	assign take     = accept && !drop;

	always_comb begin
		ic          = (WEW'(in_col_q) >= width_eff) ? '0 : in_col_q;
		emit        = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (ic != '0));
		pre         = (WX'(out_col_q) + WX'(1)) >= WX'(width_eff);
		col_end     = (WX'(ic) + WX'(1)) >= WX'(width_eff);
		in_last_row = (HX'(in_row_q) + HX'(1)) >= HX'(height_eff);
		last        = pre && ((HX'(out_row_q) + HX'(1)) >= HX'(height_eff));
		ctl.emit       = emit;
		ctl.pre        = pre;
		ctl.left_edge  = (out_col_q == '0);
		ctl.top_first  = (out_row_q == '0);
		ctl.bot_last   = (HX'(out_row_q) + HX'(1)) >= HX'(height_eff);
		ctl.last       = last;
		ctl.parity     = in_row_q[0];
		ctl.pos.column = POS_W'(out_col_q);
		ctl.pos.row    = POS_W'(out_row_q);
		ctl.pos.last   = last;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rd0_s1 <= bank0_q[ic];
			if (!mode && !in_row_q[0]) begin
				bank0_q[ic] <= height_sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rd1_s1 <= bank1_q[ic];
			if (!mode && in_row_q[0]) begin
				bank1_q[ic] <= height_sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1    <= ctl;
			sample_s1 <= mode ? '0 : height_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			loaded_q  <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (frame_clear || (take && emit && last)) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				loaded_q  <= 1'b0;
			end else if (take) begin
				if (!mode && in_last_row && col_end) begin
					loaded_q <= 1'b1;
				end
				in_col_q <= col_end ? '0 : ic + CW'(1);
				in_row_q <= col_end ? in_row_q + RW'(1) : in_row_q;
				if (emit) begin
					out_col_q <= pre ? '0 : out_col_q + CW'(1);
					out_row_q <= pre ? out_row_q + ORW'(1) : out_row_q;
				end
			end
		end
	end

	// window column 2 is the newest; the left/center taps are the same either way
	logic signed [HB-1:0] ncol [3];
	logic signed [HB-1:0] lcol [3];
	logic signed [HB-1:0] ccol [3];
	logic signed [HB-1:0] rcol [3];
	logic [1:0] t_idx, b_idx;

	always_comb begin
		ncol[0] = ctl_s1.parity ? rd1_s1 : rd0_s1;
		ncol[1] = ctl_s1.parity ? rd0_s1 : rd1_s1;
		ncol[2] = sample_s1;
		for (int r = 0; r < 3; r++) begin
			lcol[r] = ctl_s1.left_edge ? win_q[r][2] : win_q[r][1];
			ccol[r] = win_q[r][2];
			rcol[r] = ctl_s1.pre ? win_q[r][2] : ncol[r];
		end
		t_idx = ctl_s1.top_first ? 2'd1 : 2'd0;
		b_idx = ctl_s1.bot_last ? 2'd1 : 2'd2;
	end

	always_comb begin
		logic signed [DW-1:0] l_t, c_t, r_t, l_b, c_b, r_b, l_m, r_m;
		l_t = DW'(lcol[t_idx]);
		c_t = DW'(ccol[t_idx]);
		r_t = DW'(rcol[t_idx]);
		l_b = DW'(lcol[b_idx]);
		c_b = DW'(ccol[b_idx]);
		r_b = DW'(rcol[b_idx]);
		l_m = DW'(lcol[1]);
		r_m = DW'(rcol[1]);
		push_dx = (l_t + (c_t <<< 1) + r_t) - (l_b + (c_b <<< 1) + r_b);
		push_dz = (l_t + (l_m <<< 1) + l_b) - (r_t + (r_m <<< 1) + r_b);
	end

	assign push     = valid_s1 && ctl_s1.emit;
	assign push_pos = ctl_s1.pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (frame_clear || (valid_s1 && ctl_s1.emit && ctl_s1.last)) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= ncol[r];
			end
		end
	end

endmodule

[src/snh_queue.sv]
// Short job queue between front and back ends.
// Uses snh_pkg for the depth.
module snh_queue
	import snh_pkg::*;
#(
	parameter int DW = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [DW-1:0]                    push_data,
	input  logic                             pop,
	output logic [DW-1:0]                    pop_data,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
	output logic                             empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	logic [DW-1:0] entries_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign count    = count_q;
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCW'(QUEUE_DEPTH)))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

[src/snh_back.sv]
// Back end: scales the differences, normalizes (nx, 1, nz) with an iterative
// square root and three bit-serial dividers, and holds the output word. Uses snh_pkg.
module snh_back
	import snh_pkg::*;
#(
	parameter int HEIGHT_BITS = 16,
	localparam int DW = HEIGHT_BITS + 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [DISP_W-1:0]        displacement,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  logic signed [DW-1:0]     q_dx,
	input  logic signed [DW-1:0]     q_dz,
	input  pos_t                     q_pos,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  normal_x,
	output logic signed [OUT_W-1:0]  normal_y,
	output logic signed [OUT_W-1:0]  normal_z,
	output logic [POS_W-1:0]         column,
	output logic [POS_W-1:0]         row,
	output logic                     last_of_frame
);

	localparam int PW   = DW + DISP_W + 1;
	localparam int MW   = (PW > NORM_W + 1) ? PW : NORM_W + 1;
	localparam int KW   = $clog2(MW - NORM_W + 1);

	back_state_t st_q, st_d;

	logic signed [DW-1:0] dx_q, dz_q;
	pos_t                 pos_q;
	logic signed [PW-1:0] nx_q, nz_q;
	logic [NORM_W-1:0]    ax_q, ay_q, az_q;
	logic                 negx_q, negz_q;
	logic [SQ_W-1:0]      acc_q, rem_q, res_q, bit_q;
	logic [STEP_W-1:0]    cnt_q;
	logic [DIV_W-1:0]     dvs_q, rx_q, ry_q, rz_q;
	logic [QUOT_W-1:0]    qx_q, qy_q, qz_q;
	logic                 out_valid_q;

	logic out_free, load_out;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: if (!q_empty) st_d = B_MUL;
			B_MUL:  st_d = B_NORM;
			B_NORM: st_d = B_SQ;
			B_SQ:   if (cnt_q == STEP_W'(2)) st_d = B_SQRT;
			B_SQRT: if (cnt_q == STEP_W'(ROOT_STEPS - 1)) st_d = B_PREP;
			B_PREP: st_d = B_DIV;
			B_DIV:  if (cnt_q == STEP_W'(DIV_STEPS - 1)) st_d = B_DONE;
			B_DONE: if (out_free) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (st_q == B_IDLE) && !q_empty;
		load_out = (st_q == B_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	logic [MW-1:0]     ax_w, az_w, m_w;
	logic [KW-1:0]     k_w;
	logic [NORM_W-1:0] sq_sel;
	logic [SQ_W-1:0]   root_try;
	logic [DIV_W-1:0]  root_dvs;

	always_comb begin
		ax_w = negx_q ? MW'(-nx_q) : MW'(nx_q);
		az_w = negz_q ? MW'(-nz_q) : MW'(nz_q);
		m_w  = (ax_w > az_w) ? ax_w : az_w;
		k_w  = '0;
		for (int i = NORM_W; i < MW; i++) begin
			if (m_w[i]) k_w = KW'(i - NORM_W + 1);
		end
		case (cnt_q[1:0])
			2'd0:    sq_sel = ax_q;
			2'd1:    sq_sel = ay_q;
			default: sq_sel = az_q;
		endcase
		root_try = res_q + bit_q;
		root_dvs = DIV_W'({res_q[ROOT_W-1:0], 1'b0}) << 16;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				dx_q  <= q_dx;
				dz_q  <= q_dz;
				pos_q <= q_pos;
			end
			B_MUL: begin
				nx_q   <= PW'(dx_q) * PW'($signed({1'b0, displacement}));
				nz_q   <= PW'(dz_q) * PW'($signed({1'b0, displacement}));
				negx_q <= dx_q[DW-1] && (displacement != '0);
				negz_q <= dz_q[DW-1] && (displacement != '0);
			end
			B_NORM: begin
				ax_q  <= NORM_W'(ax_w >> k_w);
				az_q  <= NORM_W'(az_w >> k_w);
				ay_q  <= NORM_W'(32'h0001_0000 >> k_w);
				acc_q <= '0;
				cnt_q <= '0;
			end
			B_SQ: begin
				acc_q <= acc_q + SQ_W'(sq_sel * sq_sel);
				if (cnt_q == STEP_W'(2)) begin
					cnt_q <= '0;
					rem_q <= acc_q + SQ_W'(sq_sel * sq_sel);
					res_q <= '0;
					bit_q <= SQ_W'(1) << (SQ_W - 2);
				end else begin
					cnt_q <= cnt_q + STEP_W'(1);
				end
			end
			B_SQRT: begin
				if (rem_q >= root_try) begin
					rem_q <= rem_q - root_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + STEP_W'(1);
			end
			B_PREP: begin
				dvs_q <= root_dvs;
				rx_q  <= DIV_W'({ax_q, 16'h0000}) + DIV_W'(res_q[ROOT_W-1:0]);
				ry_q  <= DIV_W'({ay_q, 16'h0000}) + DIV_W'(res_q[ROOT_W-1:0]);
				rz_q  <= DIV_W'({az_q, 16'h0000}) + DIV_W'(res_q[ROOT_W-1:0]);
				qx_q  <= '0;
				qy_q  <= '0;
				qz_q  <= '0;
				cnt_q <= '0;
			end
			B_DIV: begin
				if (rx_q >= dvs_q) rx_q <= rx_q - dvs_q;
				if (ry_q >= dvs_q) ry_q <= ry_q - dvs_q;
				if (rz_q >= dvs_q) rz_q <= rz_q - dvs_q;
				qx_q  <= {qx_q[QUOT_W-2:0], rx_q >= dvs_q};
				qy_q  <= {qy_q[QUOT_W-2:0], ry_q >= dvs_q};
				qz_q  <= {qz_q[QUOT_W-2:0], rz_q >= dvs_q};
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			normal_x      <= to_q15(negx_q, qx_q);
			normal_y      <= to_q15(1'b0, qy_q);
			normal_z      <= to_q15(negz_q, qz_q);
			column        <= pos_q.column;
			row           <= pos_q.row;
			last_of_frame <= pos_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[src/sobel_heightmap_normals.sv]
// Top level of the Sobel height-map normal generator: configuration registers,
// front end, job queue and normalizing back end. Uses snh_pkg, snh_front, snh_queue, snh_back.
//
//   channel | handshake           | word
//   input   | in_valid / in_stall | mode, height_sample
//   output  | out_valid/out_stall | normal_x/y/z, column, row, last_of_frame
//   config  | cfg_write_en        | cfg_index, cfg_data
//
// Front end takes one word per cycle while the queue has room; the back end
// handles one normal at a time (32-step square root, 17-step divide), which
// sets the sustained rate. Words that produce no normal take no queue entry.
// Reset clears counters, window and queue; the line store needs no clearing.
// A stalled output word holds; the back end waits in its final step meanwhile.
module sobel_heightmap_normals
	import snh_pkg::*;
#(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 1024,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic signed [HEIGHT_BITS-1:0] height_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [OUT_W-1:0]       normal_x,
	output logic signed [OUT_W-1:0]       normal_y,
	output logic signed [OUT_W-1:0]       normal_z,
	output logic [POS_W-1:0]              column,
	output logic [POS_W-1:0]              row,
	output logic                          last_of_frame
);

	localparam int WEW = $clog2(MAX_WIDTH + 1);
	localparam int HEW = $clog2(MAX_HEIGHT + 1);
	localparam int DW  = HEIGHT_BITS + 3;
	localparam int JW  = 2 * DW + $bits(pos_t);

	logic [10:0]       map_width_q, map_height_q;
	logic [DISP_W-1:0] displacement_q;
	logic [WEW-1:0]    width_eff;
	logic [HEW-1:0]    height_eff;
	logic              frame_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q    <= 11'd1024;
			map_height_q   <= 11'd1024;
			displacement_q <= DISP_W'(256);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:    map_width_q <= cfg_data[10:0];
				REG_MAP_HEIGHT:   map_height_q <= cfg_data[10:0];
				REG_DISPLACEMENT: displacement_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign frame_clear = cfg_write_en &&
		((cfg_index == REG_MAP_WIDTH) || (cfg_index == REG_MAP_HEIGHT));

	always_comb begin
		if (map_width_q == '0) width_eff = WEW'(1);
		else if (32'(map_width_q) > MAX_WIDTH) width_eff = WEW'(MAX_WIDTH);
		else width_eff = WEW'(map_width_q);
		if (map_height_q == '0) height_eff = HEW'(1);
		else if (32'(map_height_q) > MAX_HEIGHT) height_eff = HEW'(MAX_HEIGHT);
		else height_eff = HEW'(map_height_q);
	end

	logic                          push, pop, q_empty;
	logic signed [DW-1:0]          push_dx, push_dz;
	pos_t                          push_pos;
	logic [JW-1:0]                 pop_data;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
	logic signed [DW-1:0]          job_dx, job_dz;
	pos_t                          job_pos;

	snh_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.height_sample(height_sample),
		.width_eff    (width_eff),
		.height_eff   (height_eff),
		.frame_clear  (frame_clear),
		.q_count      (q_count),
		.push         (push),
		.push_dx      (push_dx),
		.push_dz      (push_dz),
		.push_pos     (push_pos)
	);

	snh_queue #(
		.DW(JW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_dx, push_dz, push_pos}),
		.pop      (pop),
		.pop_data (pop_data),
		.count    (q_count),
		.empty    (q_empty)
	);

	assign {job_dx, job_dz, job_pos} = pop_data;

	snh_back #(
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.displacement (displacement_q),
		.q_empty      (q_empty),
		.q_pop        (pop),
		.q_dx         (job_dx),
		.q_dz         (job_dz),
		.q_pos        (job_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.column       (column),
		.row          (row),
		.last_of_frame(last_of_frame)
	);

endmodule

[tb/sv/snh_normal_checker.sv]
`timescale 1ns / 100ps
// Checker for sobel_heightmap_normals: watches config writes and both word channels,
// predicts each normal and compares it field by field. Depends on snh_pkg.
module snh_normal_checker
	import snh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  mode,
	input  logic signed [15:0]    height_sample,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic signed [15:0]    normal_x,
	input  logic signed [15:0]    normal_y,
	input  logic signed [15:0]    normal_z,
	input  logic [POS_W-1:0]      column,
	input  logic [POS_W-1:0]      row,
	input  logic                  last_of_frame,
	output int                    errors,
	output int                    outstanding,
	output int                    checked
);

	localparam int MAXW = 1024;
	localparam int MAXH = 1024;

	typedef struct {
		logic [15:0]      nx;
		logic [15:0]      ny;
		logic [15:0]      nz;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] rw;
		logic             last;
	} normal_word_t;

	normal_word_t expected_normals[$];

	longint      line_mem[0:2*MAXW-1];
	longint      win[3][3];
	int unsigned in_col, in_row, out_col, out_row;
	bit          loaded;
	int unsigned map_w, map_h, disp;

	assign outstanding = expected_normals.size();

	function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] scale_q15(bit neg, longint unsigned a, longint unsigned q);
		longint unsigned v;
		v = (q == 0) ? 32767 : (65536 * a + q) / (2 * q);
		if (v > 32767) v = 32767;
		return neg ? 16'(65536 - v) : 16'(v);
	endfunction

	task automatic sobel_normal(input int cc, input int lc, input int rc, input int unsigned h,
			output logic [15:0] x, output logic [15:0] y, output logic [15:0] z);
		int t, b, k;
		longint dx, dz, nx, nz;
		longint unsigned ax, ay, az, m, q;
		t = (out_row == 0) ? 1 : 0;
		b = (out_row + 1 >= h) ? 1 : 2;
		dx = (win[t][lc] + 2 * win[t][cc] + win[t][rc]) - (win[b][lc] + 2 * win[b][cc] + win[b][rc]);
		dz = (win[t][lc] + 2 * win[1][lc] + win[b][lc]) - (win[t][rc] + 2 * win[1][rc] + win[b][rc]);
		nx = dx * longint'(disp);
		nz = dz * longint'(disp);
		ax = (nx < 0) ? -nx : nx;
		az = (nz < 0) ? -nz : nz;
		ay = 65536;
		m = (ax > az) ? ax : az;
		if (ay > m) m = ay;
		k = 0;
		while ((m >> k) >= (64'd1 << 31)) k++;
		ax >>= k;
		ay >>= k;
		az >>= k;
		q = int_sqrt(ax * ax + ay * ay + az * az);
		x = scale_q15(nx < 0, ax, q);
		y = scale_q15(0, ay, q);
		z = scale_q15(nz < 0, az, q);
	endtask

	task automatic clear_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		loaded = 0;
		foreach (win[i, j]) win[i][j] = 0;
	endtask

	task automatic predict_word(input logic m, input logic signed [15:0] hs);
		int unsigned w, h, ir, ic;
		bit emit, pre;
		longint top_h, mid_h, bot_h;
		normal_word_t e;
		w = clamp_size(map_w, MAXW);
		h = clamp_size(map_h, MAXH);
		ir = in_row;
		ic = in_col;
		if (m && !loaded) return;
		if (!m && loaded) return;
		if (ic >= w) ic = 0;
		emit = (ir >= 2) || (ir == 1 && ic >= 1);
		pre = (out_col + 1 >= w);
		top_h = line_mem[(ir & 1) * MAXW + ic];
		mid_h = line_mem[((ir + 1) & 1) * MAXW + ic];
		bot_h = 0;
		if (!m) begin
			bot_h = longint'(hs);
			line_mem[(ir & 1) * MAXW + ic] = bot_h;
		end
		if (emit && pre)
			sobel_normal(2, (out_col == 0) ? 2 : 1, 2, h, e.nx, e.ny, e.nz);
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top_h;
		win[1][2] = mid_h;
		win[2][2] = bot_h;
		if (emit && !pre)
			sobel_normal(1, (out_col == 0) ? 1 : 0, 2, h, e.nx, e.ny, e.nz);
		if (!m && ir + 1 >= h && ic + 1 >= w) loaded = 1;
		ic++;
		if (ic >= w) begin
			ic = 0;
			ir++;
		end
		in_col = ic;
		in_row = ir;
		if (!emit) return;
		e.last = (out_row + 1 >= h) && (out_col + 1 >= w);
		e.col = POS_W'(out_col);
		e.rw = POS_W'(out_row);
		expected_normals.push_back(e);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		if (e.last) clear_frame();
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		normal_word_t e;
		if (!arst_n) begin
			foreach (line_mem[i]) line_mem[i] = 0;
			clear_frame();
			map_w = 1024;
			map_h = 1024;
			disp = 256;
			expected_normals.delete();
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_MAP_WIDTH: begin
						map_w = cfg_data & 16'h07FF;
						clear_frame();
					end
					REG_MAP_HEIGHT: begin
						map_h = cfg_data & 16'h07FF;
						clear_frame();
					end
					REG_DISPLACEMENT: disp = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) predict_word(mode, height_sample);
			if (out_valid && !out_stall) begin
				if (expected_normals.size() == 0) begin
					report("unexpected word, row", row, -1);
				end else begin
					e = expected_normals.pop_front();
					checked++;
					if (normal_x !== e.nx) report("normal_x", $signed(normal_x), $signed(e.nx));
					if (normal_y !== e.ny) report("normal_y", $signed(normal_y), $signed(e.ny));
					if (normal_z !== e.nz) report("normal_z", $signed(normal_z), $signed(e.nz));
					if (column !== e.col) report("column", column, e.col);
					if (row !== e.rw) report("row", row, e.rw);
					if (last_of_frame !== e.last) report("last_of_frame", last_of_frame, e.last);
				end
			end
		end
	end

endmodule

[tb/sv/sobel_heightmap_normals_test.sv]
`timescale 1ns / 100ps
// Top of the sobel_heightmap_normals testbench: clock, reset, configuration and
// word stimulus with random gaps and output stalls. Uses snh_pkg, sobel_heightmap_normals and snh_normal_checker.
module sobel_heightmap_normals_test;
	import snh_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  mode;
	logic signed [15:0]    height_sample;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [15:0]    normal_x, normal_y, normal_z;
	logic [POS_W-1:0]      column, row;
	logic                  last_of_frame;
	int                    errors, outstanding, checked;
	int                    words_sent;
	int                    frames_done;
	bit                    quiet;
	int                    stall_run;

	sobel_heightmap_normals u_top (.*);

	snh_normal_checker u_chk (.*);

	initial clk = 0;
	always #5 clk = ~clk;

	initial begin
		#40ms;
		$display("timeout");
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (!arst_n || quiet) begin
			out_stall <= 0;
			stall_run <= 0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else if ($urandom_range(0, 99) < 30) begin
			out_stall <= 1;
			stall_run <= pick_gap() + 1;
		end else begin
			out_stall <= 0;
			stall_run <= $urandom_range(0, 30);
		end
	end

	task automatic send_word(input logic m, input logic signed [15:0] hv);
		int n;
		n = pick_gap();
		if (n > 0) begin
			in_valid = 0;
			repeat (n) @(negedge clk);
		end
		in_valid = 1;
		mode = m;
		height_sample = hv;
		#1;
		while (in_stall) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
		in_valid = 0;
		words_sent++;
	endtask

	task automatic settle();
		while (outstanding != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_write_en = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write_en = 0;
	endtask

	function automatic logic signed [15:0] pick_height(input int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 64)) - 16'sd32;
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'($urandom);
				endcase
			end
		endcase
	endfunction

	// One frame in raster order plus its drain words. Noise: stray drains before the
	// last sample, stray samples during draining, extra drains at the end.
	// abort_at >= 0 stops after that many samples and restarts via a width write.
	task automatic run_frame(input int w, input int h, input int style, input int noise,
			input int disp_at, input int abort_at);
		for (int i = 0; i < w * h; i++) begin
			if (i == abort_at) begin
				settle();
				write_reg(REG_MAP_WIDTH, 16'(w));
				return;
			end
			if (i == disp_at) begin
				settle();
				write_reg(REG_DISPLACEMENT, 16'($urandom));
			end
			if ($urandom_range(0, 99) < noise) send_word(1, 16'($urandom));
			send_word(0, pick_height(style));
		end
		for (int i = 0; i < w + 1; i++) begin
			if ($urandom_range(0, 99) < noise) send_word(0, 16'($urandom));
			send_word(1, 16'($urandom));
		end
		if ($urandom_range(0, 99) < noise) send_word(1, 16'($urandom));
		frames_done++;
	endtask

	initial begin
		int w, h;
		arst_n = 0;
		cfg_write_en = 0;
		cfg_index = REG_MAP_WIDTH;
		cfg_data = 0;
		in_valid = 0;
		mode = 0;
		height_sample = 0;
		quiet = 0;
		words_sent = 0;
		frames_done = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_word(1, 0);
		write_reg(REG_MAP_WIDTH, 3);
		write_reg(REG_MAP_HEIGHT, 3);
		write_reg(REG_DISPLACEMENT, 256);
		run_frame(3, 3, 2, 30, -1, -1);
		settle();
		write_reg(REG_DISPLACEMENT, 16'hFFFF);
		run_frame(3, 3, 2, 0, -1, -1);
		settle();
		write_reg(REG_DISPLACEMENT, 0);
		run_frame(3, 3, 0, 0, -1, -1);
		settle();
		write_reg(REG_MAP_WIDTH, 0);
		write_reg(REG_MAP_HEIGHT, 1);
		write_reg(REG_DISPLACEMENT, 16'h0180);
		run_frame(1, 1, 0, 0, -1, -1);
		settle();
		write_reg(REG_MAP_WIDTH, 2);
		write_reg(REG_MAP_HEIGHT, 0);
		run_frame(2, 1, 0, 0, -1, -1);
		settle();
		write_reg(REG_MAP_WIDTH, 4);
		write_reg(REG_MAP_HEIGHT, 4);
		run_frame(4, 4, 0, 0, -1, 7);
		run_frame(4, 4, 1, 0, 8, -1);
		settle();
		// oversized width clamps to the full line; the first normals of row 0 prove it
		quiet = 1;
		write_reg(REG_MAP_WIDTH, 16'hFFFF);
		write_reg(REG_MAP_HEIGHT, 2);
		run_frame(1024, 2, 0, 0, -1, 1030);
		quiet = 0;

		while (words_sent < 1650) begin
			if ($urandom_range(0, 9) < 8) begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 6);
			end else begin
				w = $urandom_range(1, 40);
				h = $urandom_range(1, 12);
			end
			quiet = ($urandom_range(0, 5) == 0);
			settle();
			write_reg(REG_MAP_WIDTH, 16'(w));
			write_reg(REG_MAP_HEIGHT, 16'(h));
			case ($urandom_range(0, 5))
				0: write_reg(REG_DISPLACEMENT, 0);
				1: write_reg(REG_DISPLACEMENT, 16'hFFFF);
				2: write_reg(REG_DISPLACEMENT, 256);
				default: write_reg(REG_DISPLACEMENT, 16'($urandom));
			endcase
			run_frame(w, h, $urandom_range(0, 2), ($urandom_range(0, 3) == 0) ? 10 : 0,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : -1,
				($urandom_range(0, 11) == 0) ? $urandom_range(1, w * h) : -1);
		end
		settle();

		$display("frames completed %0d, normals compared %0d, mismatches %0d",
			frames_done, checked, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[sim.f]
src/snh_pkg.sv
src/snh_front.sv
src/snh_queue.sv
src/snh_back.sv
src/sobel_heightmap_normals.sv
tb/sv/snh_normal_checker.sv
tb/sv/sobel_heightmap_normals_test.sv
